// ===== hw/rtl/bmgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmgs_pkg
// Shared types and constants of the binary majority grid smoother.
// ----------------------------------------------------------------------------
package bmgs_pkg;

   localparam int DEF_MAX_WIDTH = 64;
   localparam int DEF_MAX_DEPTH = 64;

   localparam int ELEV_W    = 16;
   localparam int DIM_W     = 7;
   localparam int PASS_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int COL_IN_W  = 6;
   localparam int ROW_IN_W  = 6;

   localparam logic [3:0] KEEP_LAND  = 4'd4;
   localparam logic [3:0] BIRTH_LAND = 4'd5;

   localparam logic [DIM_W-1:0]  RST_GRID_WIDTH = 7'd64;
   localparam logic [DIM_W-1:0]  RST_GRID_DEPTH = 7'd64;
   localparam logic [PASS_W-1:0] RST_PASS_COUNT = 4'd2;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH = 2'd0,
      REG_GRID_DEPTH = 2'd1,
      REG_PASS_COUNT = 2'd2
   } reg_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic idle;
      logic accept;
      logic rsp_load;
      logic land_rd;
      logic land_wr;
      logic nbr_rd;
      logic nwr;
      logic frd;
      logic fwr;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_run;
      logic pass_zero;
      logic rsp_free;
      logic cell_last;
      logic k_last;
      logic pass_last;
   } ctl_sts_type;

endpackage

// ===== hw/rtl/bmgs_ram.sv =====
// ----------------------------------------------------------------------------
// bmgs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bmgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmgs_ctrl
// Sequencer of the smoother: command handling, land map build, automaton
// passes and the final class forcing sweep.
// ----------------------------------------------------------------------------
module bmgs_ctrl
   import bmgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_RESP     = 9'b000000010,
      ST_LAND_RD  = 9'b000000100,
      ST_LAND_WR  = 9'b000001000,
      ST_NBR_RD   = 9'b000010000,
      ST_NBR_WAIT = 9'b000100000,
      ST_NBR_WR   = 9'b001000000,
      ST_FRC_RD   = 9'b010000000,
      ST_FRC_WR   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (sts.req_run && !sts.pass_zero) ? ST_LAND_RD : ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LAND_RD: begin
            cmd.land_rd = 1'b1;
            state_in    = ST_LAND_WR;
         end
         ST_LAND_WR: begin
            cmd.land_wr = 1'b1;
            state_in    = sts.cell_last ? ST_NBR_RD : ST_LAND_RD;
         end
         ST_NBR_RD: begin
            cmd.nbr_rd = 1'b1;
            state_in   = sts.k_last ? ST_NBR_WAIT : ST_NBR_RD;
         end
         ST_NBR_WAIT: begin
            state_in = ST_NBR_WR;
         end
         ST_NBR_WR: begin
            cmd.nwr  = 1'b1;
            state_in = (sts.cell_last && sts.pass_last) ? ST_FRC_RD : ST_NBR_RD;
         end
         ST_FRC_RD: begin
            cmd.frd  = 1'b1;
            state_in = ST_FRC_WR;
         end
         ST_FRC_WR: begin
            cmd.fwr  = 1'b1;
            state_in = sts.cell_last ? ST_RESP : ST_FRC_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A cell update is written only after all nine map reads have been issued.
   a_nwr_after_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.nwr |-> $past(cmd.nbr_rd, 2))
      else $error("cell update without neighborhood reads");

   // A forced elevation follows the read of its cell.
   a_fwr_after_frd: assert property (@(posedge clock) disable iff (reset)
      cmd.fwr |-> $past(cmd.frd))
      else $error("forcing write without read");

   // An accepted word always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !cmd.idle)
      else $error("stayed idle after accept");

endmodule

// ===== hw/rtl/bmgs_dpath.sv =====
// ----------------------------------------------------------------------------
// bmgs_dpath
// Datapath: configuration registers, elevation store, ping-pong land maps,
// cell counters, neighbor counting, class forcing and the result register.
// ----------------------------------------------------------------------------
module bmgs_dpath
   import bmgs_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_cmd_type                 cmd,
   output ctl_sts_type                 sts,
   input  logic [1:0]                  req_command,
   input  logic [COL_IN_W-1:0]         req_column,
   input  logic [ROW_IN_W-1:0]         req_row,
   input  logic signed [ELEV_W-1:0]    req_elevation_in,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic signed [ELEV_W-1:0]    rsp_elevation_out,
   output logic                        rsp_status,
   input  logic                        csr_valid,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DIM_W-1:0]            csr_wdata
);

   localparam int CELLS = MAX_WIDTH * MAX_DEPTH;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_DEPTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int DW    = $clog2(MAX_DEPTH + 1);

   logic [DIM_W-1:0]  width_ff, depth_ff;
   logic [PASS_W-1:0] pass_cnt_ff;
   logic [1:0]        op_ff;
   logic              bad_ff;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [1:0]        kr_ff, kr_in, kc_ff, kc_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              sel_ff, sel_in;
   logic [3:0]        count_ff, count_in;
   logic              center_ff, center_in;
   logic              pend_ff, pend_ctr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [ELEV_W-1:0] rsp_elev_ff, rsp_elev_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [WW-1:0]     w_eff;
   logic [DW-1:0]     d_eff;
   logic              req_bad, col_end, cell_last, interior, k_first;
   logic [AW-1:0]     req_addr, cell_addr, nb_addr;

   logic              ev_we, ev_re;
   logic [AW-1:0]     ev_waddr, ev_raddr;
   logic [ELEV_W-1:0] ev_wdata, ev_rdata;
   logic signed [ELEV_W-1:0] forced;

   logic              m0_we, m1_we, m0_re, m1_re;
   logic              m0_wdata, map_new, land_bit;
   logic [AW-1:0]     m_raddr;
   logic              m0_rdata, m1_rdata, m_rdata;

   // Grid size, with zero acting as one and oversize acting as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (depth_ff == '0) begin
         d_eff = DW'(1);
      end else if (int'(depth_ff) > MAX_DEPTH) begin
         d_eff = DW'(MAX_DEPTH);
      end else begin
         d_eff = DW'(depth_ff);
      end
   end

   assign req_bad   = (int'(req_column) >= int'(w_eff)) || (int'(req_row) >= int'(d_eff));
   assign col_end   = int'(col_ff) == int'(w_eff) - 1;
   assign cell_last = col_end && (int'(row_ff) == int'(d_eff) - 1);
   assign interior  = (row_ff != '0) && (int'(row_ff) + 1 < int'(d_eff))
                   && (col_ff != '0) && (int'(col_ff) + 1 < int'(w_eff));
   assign k_first   = (kr_ff == 2'd0) && (kc_ff == 2'd0);

   assign req_addr  = AW'(int'(req_row) * MAX_WIDTH + int'(req_column));
   assign cell_addr = AW'(int'(row_ff) * MAX_WIDTH + int'(col_ff));
   // Border cells wrap here; their neighbor counts are never used.
   assign nb_addr   = AW'((int'(row_ff) + int'(kr_ff) - 1) * MAX_WIDTH
                          + int'(col_ff) + int'(kc_ff) - 1);

   assign sts.req_run   = req_command == CMD_RUN;
   assign sts.pass_zero = pass_cnt_ff == '0;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.cell_last = cell_last;
   assign sts.k_last    = (kr_ff == 2'd2) && (kc_ff == 2'd2);
   assign sts.pass_last = pass_ff == (pass_cnt_ff - PASS_W'(1));

   // Class forcing of one elevation.
   always_comb begin
      logic signed [ELEV_W-1:0] v;
      v = $signed(ev_rdata);
      if (m_rdata) begin
         if (v > 0) begin
            forced = v;
         end else if (v < -16'sd32766) begin
            forced = 16'sd32767;
         end else begin
            forced = ELEV_W'(-v + 16'sd1);
         end
      end else begin
         if (v < 0) begin
            forced = v;
         end else begin
            forced = ELEV_W'(-v - 16'sd1);
         end
      end
   end

   assign land_bit = $signed(ev_rdata) > 0;
   assign map_new  = !interior ? center_ff
                   : (center_ff ? (count_ff >= KEEP_LAND) : (count_ff >= BIRTH_LAND));

   // Elevation store ports.
   assign ev_we    = (cmd.accept && req_command == CMD_WRITE && !req_bad) || cmd.fwr;
   assign ev_waddr = cmd.fwr ? cell_addr : req_addr;
   assign ev_wdata = cmd.fwr ? forced : req_elevation_in;
   assign ev_re    = (cmd.accept && req_command == CMD_READ && !req_bad)
                   || cmd.land_rd || cmd.frd;
   assign ev_raddr = cmd.accept ? req_addr : cell_addr;

   // Land maps: the bank selected by sel_ff is the current map.
   assign m0_we    = cmd.land_wr || (cmd.nwr && sel_ff);
   assign m0_wdata = cmd.land_wr ? land_bit : map_new;
   assign m1_we    = cmd.nwr && !sel_ff;
   assign m0_re    = (cmd.nbr_rd || cmd.frd) && !sel_ff;
   assign m1_re    = (cmd.nbr_rd || cmd.frd) && sel_ff;
   assign m_raddr  = cmd.nbr_rd ? nb_addr : cell_addr;
   assign m_rdata  = sel_ff ? m1_rdata : m0_rdata;

   bmgs_ram #(.WIDTH(ELEV_W), .DEPTH(CELLS)) u_elev_ram (
      .clock   (clock),
      .wr_en   (ev_we),
      .wr_addr (ev_waddr),
      .wr_data (ev_wdata),
      .rd_en   (ev_re),
      .rd_addr (ev_raddr),
      .rd_data (ev_rdata)
   );

   bmgs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map0_ram (
      .clock   (clock),
      .wr_en   (m0_we),
      .wr_addr (cell_addr),
      .wr_data (m0_wdata),
      .rd_en   (m0_re),
      .rd_addr (m_raddr),
      .rd_data (m0_rdata)
   );

   bmgs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map1_ram (
      .clock   (clock),
      .wr_en   (m1_we),
      .wr_addr (cell_addr),
      .wr_data (map_new),
      .rd_en   (m1_re),
      .rd_addr (m_raddr),
      .rd_data (m1_rdata)
   );

   // Counters for the grid walk and the neighborhood.
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      kr_in     = kr_ff;
      kc_in     = kc_ff;
      pass_in   = pass_ff;
      sel_in    = sel_ff;
      count_in  = count_ff;
      center_in = center_ff;
      if (cmd.accept) begin
         row_in  = '0;
         col_in  = '0;
         kr_in   = 2'd0;
         kc_in   = 2'd0;
         pass_in = '0;
         sel_in  = 1'b0;
      end
      if (cmd.land_wr || cmd.nwr || cmd.fwr) begin
         if (cell_last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (cmd.nwr && cell_last) begin
         sel_in  = !sel_ff;
         pass_in = pass_ff + PASS_W'(1);
      end
      if (cmd.nbr_rd) begin
         if (kc_ff == 2'd2) begin
            kc_in = 2'd0;
            kr_in = (kr_ff == 2'd2) ? 2'd0 : kr_ff + 2'd1;
         end else begin
            kc_in = kc_ff + 2'd1;
         end
      end
      if (cmd.nbr_rd && k_first) begin
         count_in = '0;
      end else if (pend_ff && !pend_ctr_ff) begin
         count_in = count_ff + 4'(m_rdata);
      end
      if (pend_ff && pend_ctr_ff) begin
         center_in = m_rdata;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_elev_in   = rsp_elev_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_elev_in   = (op_ff == CMD_READ && !bad_ff) ? $signed(ev_rdata) : '0;
         rsp_status_in = bad_ff && (op_ff == CMD_READ || op_ff == CMD_WRITE);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RST_GRID_WIDTH;
         depth_ff     <= RST_GRID_DEPTH;
         pass_cnt_ff  <= RST_PASS_COUNT;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         kr_ff        <= 2'd0;
         kc_ff        <= 2'd0;
         pass_ff      <= '0;
         sel_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_GRID_WIDTH: width_ff    <= csr_wdata;
               REG_GRID_DEPTH: depth_ff    <= csr_wdata;
               REG_PASS_COUNT: pass_cnt_ff <= csr_wdata[PASS_W-1:0];
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= cmd.nbr_rd;
         row_ff       <= row_in;
         col_ff       <= col_in;
         kr_ff        <= kr_in;
         kc_ff        <= kc_in;
         pass_ff      <= pass_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_command;
         bad_ff <= req_bad;
      end
      pend_ctr_ff   <= (kr_ff == 2'd1) && (kc_ff == 2'd1);
      count_ff      <= count_in;
      center_ff     <= center_in;
      rsp_elev_ff   <= rsp_elev_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elevation_out = rsp_elev_ff;
   assign rsp_status        = rsp_status_ff;

   // Every neighbor read has been counted before the cell is updated.
   a_counted: assert property (@(posedge clock) disable iff (reset)
      cmd.nwr |-> !pend_ff)
      else $error("cell update with a map read still in flight");

endmodule

// ===== hw/rtl/binary_majority_grid_smoother.sv =====
// Write and read words go from accept through the response state to the result register;
// one word is in work at a time. A run over W columns and D rows builds the land map,
// makes P passes, each costing nine single-port land map reads per cell, and then sweeps
// the grid to force classes; a run with zero passes goes straight to the response state.
// Synchronous reset clears the control state and sets grid 64 x 64 and 2 passes; the
// elevation store is not cleared.
// ----------------------------------------------------------------------------
// binary_majority_grid_smoother
// Elevation grid with majority cellular-automaton smoothing of its land map.
// ----------------------------------------------------------------------------
module binary_majority_grid_smoother
   import bmgs_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [COL_IN_W-1:0]      req_column,
   input  logic [ROW_IN_W-1:0]      req_row,
   input  logic signed [ELEV_W-1:0] req_elevation_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEV_W-1:0] rsp_elevation_out,
   output logic                     rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign req_stall = !cmd.idle;
   assign csr_ready = 1'b1;

   bmgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmgs_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_DEPTH(MAX_DEPTH)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_command       (req_command),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_elevation_in  (req_elevation_in),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_elevation_out (rsp_elevation_out),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule
